[rtl/pic8259_pkg.sv]
// Shared types, codes and a helper function for the 8259-style interrupt controller.
package pic8259_pkg;

    // Item function codes
    localparam logic [1:0] FUNC_POLL  = 2'd0;
    localparam logic [1:0] FUNC_ACK   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_WRITE = 2'd3;

    // Port select codes; anything above PORT_DATA is an unrelated port
    localparam logic [1:0] PORT_CMD  = 2'd0;
    localparam logic [1:0] PORT_DATA = 2'd1;

    // Acknowledge result codes
    localparam logic [1:0] ACK_NONE    = 2'd0;
    localparam logic [1:0] ACK_CASCADE = 2'd1;
    localparam logic [1:0] ACK_VECTOR  = 2'd2;

    // Initialisation and operation command word bit positions
    localparam int ICW1_IC4    = 0;
    localparam int ICW1_SNGL   = 1;
    localparam int ICW4_UPM    = 0;
    localparam int ICW4_AEOI   = 1;
    localparam int OCW2_EOI    = 5;
    localparam int OCW2_SL     = 6;

    typedef enum logic [2:0] {
        STEP_NOT_STARTED = 3'd0,
        STEP_WORD_TWO    = 3'd2,
        STEP_WORD_THREE  = 3'd3,
        STEP_WORD_FOUR   = 3'd4,
        STEP_FINISHED    = 3'd5
    } init_step_t;

    typedef struct packed {
        logic [1:0] func;
        logic [1:0] port_sel;
        logic [7:0] write_data;
        logic [7:0] irq_lines;
    } pic_in_t;

    typedef struct packed {
        logic       int_request;
        logic [1:0] ack_kind;
        logic [7:0] vector;
        logic [7:0] read_data;
    } pic_out_t;

    // Index of the lowest set bit; bit 3 set means none
    function automatic logic [3:0] lowest_bit(input logic [7:0] v);
        logic [3:0] idx;
        idx = 4'd8;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 4'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/interrupt_controller_8259_top.sv]
// Top level of the 8259-style interrupt controller: handshakes and result register.
//
// Input words arrive on s_valid/s_ready/s_data: a poll of the request lines,
// an interrupt acknowledge, a port read or a port write. Every word gives
// exactly one result word on m_valid/m_ready/m_data.
// The result is registered and presented in the cycle after its word is
// accepted. Throughput is one word per cycle while the receiver keeps up,
// set by the single result register; the priority encoders and the
// vector add sit between the accept edge and that register.
// s_ready stays high while the result register is empty or being taken,
// so a word is accepted in the same cycle a waiting result leaves. When the
// receiver stalls, the result holds and s_ready drops until it is taken.
// The is_slave register is written through cfg_valid/cfg_data, always ready,
// and should only change while no word is in flight.
// Synchronous active-low reset clears the request, in-service and mask
// registers, the initialisation words and is_slave, and empties the output.
module interrupt_controller_8259_top (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pic8259_pkg::pic_in_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pic8259_pkg::pic_out_t m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_data
);
    import pic8259_pkg::*;

    logic     is_slave_reg;
    logic     m_valid_reg, m_valid_next;
    pic_out_t m_data_reg;
    pic_out_t result;
    logic     accept;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    pic8259_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .item     (s_data),
        .is_slave (is_slave_reg),
        .result   (result)
    );

    // Hold the word until taken, refill on accept
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            is_slave_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                is_slave_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

[rtl/pic8259_core.sv]
// Controller state and per-word request, acknowledge and port logic.
module pic8259_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  pic8259_pkg::pic_in_t  item,
    input  logic                  is_slave,
    output pic8259_pkg::pic_out_t result
);
    import pic8259_pkg::*;

    init_step_t step_reg, step_next;
    logic [7:0] request_reg, request_next;
    logic [7:0] service_reg, service_next;
    logic [7:0] mask_reg, mask_next;
    logic [7:0] icw1_reg, icw1_next;
    logic [7:0] icw2_reg, icw2_next;
    logic [7:0] icw3_reg, icw3_next;
    logic [7:0] icw4_reg, icw4_next;

    logic       is_write_cmd;
    logic       is_write_data;
    logic [3:0] poll_line;
    logic [7:0] poll_bit;
    logic       poll_hit;
    logic [3:0] ack_line;
    logic [7:0] ack_bit;
    logic [3:0] eoi_line;
    logic [7:0] base;

    always_comb begin
        is_write_cmd  = (item.func == FUNC_WRITE) && (item.port_sel == PORT_CMD);
        is_write_data = (item.func == FUNC_WRITE) && (item.port_sel == PORT_DATA);
        poll_line = lowest_bit(item.irq_lines & ~mask_reg);
        poll_bit  = 8'd1 << poll_line[2:0];
        // Blocked when the polled line's bit, as a number, is not below the whole in-service vector
        poll_hit  = (step_reg == STEP_FINISHED) && !poll_line[3]
                    && !((service_reg != 8'd0) && (poll_bit >= service_reg));
        ack_line  = lowest_bit(request_reg);
        ack_bit   = 8'd1 << ack_line[2:0];
        eoi_line  = lowest_bit(service_reg);
        if (icw4_reg[ICW4_UPM]) begin
            base = {icw2_reg[7:3], 3'b000};
        end else begin
            base = {5'd0, icw1_reg[7:5]} + {icw2_reg[4:0], 3'b000};
        end
    end

    // Initialisation sequence
    always_comb begin
        step_next = step_reg;
        if (accept && is_write_cmd && step_reg == STEP_NOT_STARTED) begin
            step_next = STEP_WORD_TWO;
        end else if (accept && is_write_data) begin
            case (step_reg)
                STEP_WORD_TWO: begin
                    if (!icw1_reg[ICW1_SNGL]) begin
                        step_next = STEP_WORD_THREE;
                    end else if (icw1_reg[ICW1_IC4]) begin
                        step_next = STEP_WORD_FOUR;
                    end else begin
                        step_next = STEP_FINISHED;
                    end
                end
                STEP_WORD_THREE: begin
                    step_next = icw1_reg[ICW1_IC4] ? STEP_WORD_FOUR : STEP_FINISHED;
                end
                STEP_WORD_FOUR: begin
                    step_next = STEP_FINISHED;
                end
                default: begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    // Register updates and result word
    always_comb begin
        request_next = request_reg;
        service_next = service_reg;
        mask_next    = mask_reg;
        icw1_next    = icw1_reg;
        icw2_next    = icw2_reg;
        icw3_next    = icw3_reg;
        icw4_next    = icw4_reg;
        result       = '0;
        case (item.func)
            FUNC_POLL: begin
                if (poll_hit) begin
                    request_next  = request_reg | poll_bit;
                    result.int_request = 1'b1;
                end
            end
            FUNC_ACK: begin
                if (!ack_line[3]) begin
                    if (!icw4_reg[ICW4_AEOI]) begin
                        service_next = service_reg | ack_bit;
                    end
                    request_next = request_reg & ~ack_bit;
                    if (!icw1_reg[ICW1_SNGL] && !is_slave && ((icw3_reg & ack_bit) != 8'd0)) begin
                        result.ack_kind = ACK_CASCADE;
                    end else begin
                        result.ack_kind = ACK_VECTOR;
                        result.vector   = base + {5'd0, ack_line[2:0]};
                    end
                end
            end
            FUNC_READ: begin
                if (item.port_sel == PORT_DATA) begin
                    result.read_data = mask_reg;
                end
            end
            default: begin
                if (is_write_cmd) begin
                    if (step_reg == STEP_NOT_STARTED) begin
                        icw1_next = item.write_data;
                    end else if (item.write_data[OCW2_EOI]) begin
                        if (item.write_data[OCW2_SL]) begin
                            service_next = service_reg & ~(8'd1 << item.write_data[2:0]);
                        end else if (!eoi_line[3]) begin
                            service_next = service_reg & ~(8'd1 << eoi_line[2:0]);
                        end
                    end
                end else if (is_write_data) begin
                    case (step_reg)
                        STEP_WORD_TWO:   icw2_next = item.write_data;
                        STEP_WORD_THREE: icw3_next = item.write_data;
                        STEP_WORD_FOUR:  icw4_next = item.write_data;
                        default:         mask_next = item.write_data;
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= STEP_NOT_STARTED;
            request_reg <= 8'd0;
            service_reg <= 8'd0;
            mask_reg    <= 8'd0;
            icw1_reg    <= 8'd0;
            icw2_reg    <= 8'd0;
            icw3_reg    <= 8'd0;
            icw4_reg    <= 8'd0;
        end else if (accept) begin
            step_reg    <= step_next;
            request_reg <= request_next;
            service_reg <= service_next;
            mask_reg    <= mask_next;
            icw1_reg    <= icw1_next;
            icw2_reg    <= icw2_next;
            icw3_reg    <= icw3_next;
            icw4_reg    <= icw4_next;
        end
    end

endmodule

[bench/interrupt_controller_8259_top_test.sv]
// Self-checking bench for the 8259-style interrupt controller: shadow model, random traffic.
`timescale 1ns / 1ps

module interrupt_controller_8259_top_test;
    import pic8259_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam logic [1:0]  PORT_OTHER  = 2'd2;

    typedef enum int { RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG } rx_style_t;

    // Shadow of the controller state; predicts one result word per accepted word.
    class pic_shadow;
        logic       slave_mode;
        logic [7:0] pending_irq;
        logic [7:0] in_service;
        logic [7:0] irq_mask;
        init_step_t step;
        logic [7:0] icw1, icw2, icw3, icw4;
        pic_out_t   due_results[$];
        int unsigned mismatches;

        function new();
            slave_mode  = 1'b0;
            pending_irq = '0;
            in_service  = '0;
            irq_mask    = '0;
            step        = STEP_NOT_STARTED;
            icw1        = '0;
            icw2        = '0;
            icw3        = '0;
            icw4        = '0;
            mismatches  = 0;
        endfunction

        function int first_set(logic [7:0] v);
            for (int i = 0; i < 8; i++) begin
                if (v[i]) begin
                    return i;
                end
            end
            return 8;
        endfunction

        function void command_write(logic [7:0] v);
            int line;
            if (step == STEP_NOT_STARTED) begin
                icw1 = v;
                step = STEP_WORD_TWO;
                return;
            end
            // only EOI is acted on, even in the middle of initialisation
            if (v[OCW2_EOI]) begin
                if (v[OCW2_SL]) begin
                    in_service[v[2:0]] = 1'b0;
                end else begin
                    line = first_set(in_service);
                    if (line < 8) begin
                        in_service[line] = 1'b0;
                    end
                end
            end
        endfunction

        function void data_write(logic [7:0] v);
            case (step)
                STEP_WORD_TWO: begin
                    icw2 = v;
                    if (!icw1[ICW1_SNGL]) begin
                        step = STEP_WORD_THREE;
                    end else if (icw1[ICW1_IC4]) begin
                        step = STEP_WORD_FOUR;
                    end else begin
                        step = STEP_FINISHED;
                    end
                end
                STEP_WORD_THREE: begin
                    icw3 = v;
                    step = icw1[ICW1_IC4] ? STEP_WORD_FOUR : STEP_FINISHED;
                end
                STEP_WORD_FOUR: begin
                    icw4 = v;
                    step = STEP_FINISHED;
                end
                default: begin
                    irq_mask = v;
                end
            endcase
        endfunction

        function void take_word(pic_in_t w);
            pic_out_t   ans;
            int         line;
            logic [7:0] bit_sel;
            logic [7:0] base;
            ans = '0;
            case (w.func)
                FUNC_POLL: begin
                    if (step == STEP_FINISHED) begin
                        line = first_set(w.irq_lines & ~irq_mask);
                        if (line < 8) begin
                            bit_sel = 8'd1 << line;
                            // blocked when the line's bit, as a number, is not below the whole in-service vector
                            if (in_service == '0 || bit_sel < in_service) begin
                                pending_irq = pending_irq | bit_sel;
                                ans.int_request = 1'b1;
                            end
                        end
                    end
                end
                FUNC_ACK: begin
                    line = first_set(pending_irq);
                    if (line < 8) begin
                        bit_sel = 8'd1 << line;
                        if (!icw4[ICW4_AEOI]) begin
                            in_service = in_service | bit_sel;
                        end
                        pending_irq = pending_irq & ~bit_sel;
                        if (!icw1[ICW1_SNGL] && !slave_mode && icw3[line]) begin
                            ans.ack_kind = ACK_CASCADE;
                        end else begin
                            if (icw4[ICW4_UPM]) begin
                                base = {icw2[7:3], 3'b000};
                            end else begin
                                base = {icw2[4:0], 3'b000} + {5'd0, icw1[7:5]};
                            end
                            ans.ack_kind = ACK_VECTOR;
                            ans.vector   = base + 8'(line);
                        end
                    end
                end
                FUNC_READ: begin
                    if (w.port_sel == PORT_DATA) begin
                        ans.read_data = irq_mask;
                    end
                end
                FUNC_WRITE: begin
                    if (w.port_sel == PORT_CMD) begin
                        command_write(w.write_data);
                    end else if (w.port_sel == PORT_DATA) begin
                        data_write(w.write_data);
                    end
                end
            endcase
            due_results.push_back(ans);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function void match_result(pic_out_t got);
            pic_out_t want;
            if (due_results.size() == 0) begin
                flag($sformatf("result word with none outstanding: irq %0h kind %0h vec %0h rd %0h",
                               got.int_request, got.ack_kind, got.vector, got.read_data));
                return;
            end
            want = due_results.pop_front();
            if (got.int_request !== want.int_request) begin
                flag($sformatf("int_request expected %0h got %0h",
                               want.int_request, got.int_request));
            end
            if (got.ack_kind !== want.ack_kind) begin
                flag($sformatf("ack_kind expected %0h got %0h", want.ack_kind, got.ack_kind));
            end
            if (got.vector !== want.vector) begin
                flag($sformatf("vector expected %0h got %0h", want.vector, got.vector));
            end
            if (got.read_data !== want.read_data) begin
                flag($sformatf("read_data expected %0h got %0h", want.read_data, got.read_data));
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pic_in_t     s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    pic_out_t    m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;

    pic_shadow   shadow;
    int unsigned cycles = 0;
    int unsigned stall_tick = 0;
    rx_style_t   rx_style = RX_OPEN;
    int          burst_left = 0;

    interrupt_controller_8259_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("interrupt_controller_8259_top_test: done, errors");
            $finish;
        end
    end

    // Receiver: switch stall pattern each time the low byte of stall_tick comes round to zero
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 1;
        if (stall_tick[7:0] == 8'd0) begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
        end
        case (rx_style)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= (stall_tick[1:0] == 2'b00);
            default:   m_ready <= (stall_tick[3:0] >= 4'd12);
        endcase
    end

    // Check results before noting new words; a word's result never leaves in its own cycle
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                shadow.match_result(m_data);
            end
            if (s_valid && s_ready) begin
                shadow.take_word(s_data);
            end
        end
    end

    function automatic pic_in_t make_word(logic [1:0] func, logic [1:0] port,
                                          logic [7:0] data, logic [7:0] lines);
        pic_in_t w;
        w.func       = func;
        w.port_sel   = port;
        w.write_data = data;
        w.irq_lines  = lines;
        return w;
    endfunction

    function automatic logic [7:0] ocw2(logic specific, logic [2:0] line);
        logic [7:0] v;
        v = {5'd0, line};
        v[OCW2_EOI] = 1'b1;
        v[OCW2_SL]  = specific;
        return v;
    endfunction

    // Mostly few bits set, so that masks leave lines open and polls pick varied lines
    function automatic logic [7:0] sparse_byte();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom);
            1:       return 8'd1 << $urandom_range(0, 7);
            2:       return 8'($urandom) & 8'($urandom);
            default: return 8'($urandom) & 8'($urandom) & 8'($urandom);
        endcase
    endfunction

    function automatic pic_in_t random_word();
        pic_in_t w;
        int      pick;
        int      sub;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 9);
        w = make_word(FUNC_POLL, 2'($urandom_range(0, 2)), 8'($urandom), sparse_byte());
        if (pick < 35) begin
            w.func = FUNC_POLL;
        end else if (pick < 60) begin
            w.func = FUNC_ACK;
        end else if (pick < 75) begin
            w.func     = FUNC_WRITE;
            w.port_sel = PORT_CMD;
            if (sub < 5) begin
                w.write_data = ocw2(1'b0, 3'($urandom));
            end else if (sub < 8) begin
                w.write_data = ocw2(1'b1, 3'($urandom));
            end
        end else if (pick < 85) begin
            w.func       = FUNC_WRITE;
            w.port_sel   = PORT_DATA;
            w.write_data = (sub == 0) ? 8'hFF : (sub == 1) ? 8'h00 : sparse_byte();
        end else if (pick < 95) begin
            w.func = FUNC_READ;
        end else begin
            w.func     = FUNC_WRITE;
            w.port_sel = PORT_OTHER;
        end
        return w;
    endfunction

    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // a third of the bursts run back to back
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
    endtask

    task automatic send_word(input pic_in_t w);
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pace();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.due_results.size() != 0);
    endtask

    task automatic set_slave(input logic v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        shadow.slave_mode = v;
    endtask

    task automatic random_run(input int count);
        for (int i = 0; i < count; i++) begin
            send_word(random_word());
        end
    endtask

    initial begin
        logic [7:0] icw1_val;
        logic [7:0] icw4_val;
        logic [7:0] plain_cmd;
        logic       sngl;
        logic       ic4;

        shadow = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_slave(1'b1);

        // Before initialisation: refused poll, empty acknowledge, mask load and reads
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'hFF));
        send_word(make_word(FUNC_ACK, PORT_DATA, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_DATA, 8'hA5, 8'($urandom)));
        send_word(make_word(FUNC_READ, PORT_DATA, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_READ, PORT_OTHER, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_OTHER, 8'hFF, 8'($urandom)));
        send_word(make_word(FUNC_READ, PORT_CMD, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_DATA, 8'h00, 8'($urandom)));

        // Initialisation sequence; single mode and IC4 vary with the seed
        sngl     = ($urandom_range(0, 3) == 0);
        ic4      = ($urandom_range(0, 3) != 0);
        icw1_val = {3'($urandom), 1'b1, 2'($urandom), 2'b00};
        icw1_val[ICW1_SNGL] = sngl;
        icw1_val[ICW1_IC4]  = ic4;
        icw4_val = 8'($urandom);
        send_word(make_word(FUNC_WRITE, PORT_CMD, icw1_val, 8'($urandom)));
        // EOI in the middle of initialisation with nothing in service
        send_word(make_word(FUNC_WRITE, PORT_CMD, ocw2(1'b0, 3'd0), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_DATA, 8'($urandom), 8'($urandom)));
        if (!sngl) begin
            send_word(make_word(FUNC_WRITE, PORT_DATA, 8'($urandom_range(1, 255)),
                                8'($urandom)));
        end
        if (ic4) begin
            send_word(make_word(FUNC_WRITE, PORT_DATA, icw4_val, 8'($urandom)));
        end

        // Priority, blocking and EOI handling
        send_word(make_word(FUNC_POLL, PORT_DATA, 8'($urandom), 8'h00));
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'hFF));
        send_word(make_word(FUNC_ACK, PORT_CMD, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'h80));
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'h01));
        plain_cmd = 8'($urandom);
        plain_cmd[OCW2_EOI] = 1'b0;
        send_word(make_word(FUNC_WRITE, PORT_CMD, plain_cmd, 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_CMD, ocw2(1'b0, 3'($urandom)), 8'($urandom)));
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'h0C));
        send_word(make_word(FUNC_ACK, PORT_CMD, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_CMD, ocw2(1'b1, 3'd2), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_DATA, 8'hFF, 8'($urandom)));
        send_word(make_word(FUNC_POLL, PORT_CMD, 8'($urandom), 8'hFF));
        send_word(make_word(FUNC_READ, PORT_DATA, 8'($urandom), 8'($urandom)));
        send_word(make_word(FUNC_WRITE, PORT_DATA, 8'h00, 8'($urandom)));

        // Random phases; drain before each register write
        drain();
        set_slave(1'b0);
        random_run(600);
        drain();
        set_slave(1'b1);
        random_run(550);
        drain();
        set_slave(1'b0);
        random_run(600);

        drain();
        repeat (4) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.due_results.size() == 0) begin
            $display("interrupt_controller_8259_top_test: done, clean");
        end else begin
            $display("interrupt_controller_8259_top_test: done, errors");
        end
        $finish;
    end

endmodule
